@@ sv/pcrle_pkg.sv @@
// Shared types, codes and helpers for the planar column RLE decoder.
`timescale 1ns / 1ps

package pcrle_pkg;

   // Parser phases
   localparam logic [2:0] PH_OPCODE  = 3'd0;
   localparam logic [2:0] PH_COUNT   = 3'd1;
   localparam logic [2:0] PH_FIRST   = 3'd2;
   localparam logic [2:0] PH_SECOND  = 3'd3;
   localparam logic [2:0] PH_LITERAL = 3'd4;
   localparam logic [2:0] PH_RUN     = 3'd5;

   // Stream opcodes
   localparam logic [7:0] OP_COPY_PREV = 8'h00;
   localparam logic [7:0] OP_FILL      = 8'h01;
   localparam logic [7:0] OP_PAIR      = 8'h02;
   localparam logic [7:0] OP_COPY_P0   = 8'h03;
   localparam logic [7:0] OP_COPY_P2   = 8'h05;
   localparam logic [7:0] OP_SET_INV   = 8'h06;
   localparam logic [7:0] OP_LITERAL   = 8'h07;

   // Item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // Register indexes
   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT    = 1'b1;

   // Value sources for a row write
   localparam logic [1:0] SRC_LIT   = 2'd0;
   localparam logic [1:0] SRC_PREV  = 2'd1;
   localparam logic [1:0] SRC_PLANE = 2'd2;

   localparam int ADDR_W = 12;   // covers the largest row store

   typedef struct packed {
      logic              we;
      logic              bank;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        plane;
      logic [1:0]        src;
      logic [7:0]        lit;
      logic [1:0]        src_plane;
      logic              invert;
      logic              emit;
      logic [6:0]        column;
      logic [8:0]        row;
      logic              want_step;
      logic              image_done;
      logic              protocol_error;
   } entry_type;

   // Planar word (byte per plane) to eight packed 4-bit pixels
   function automatic logic [31:0] make_pixels(input logic [31:0] w);
      logic [31:0] p;
      p = '0;
      for (int j = 0; j < 8; j++) begin
         for (int i = 0; i < 4; i++) begin
            p[4*j+i] = w[8*i+7-j];
         end
      end
      return p;
   endfunction

endpackage

@@ sv/pcrle_ram.sv @@
// Generic single-write, registered-read RAM.
`timescale 1ns / 1ps

module pcrle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/pcrle_fifo.sv @@
// Two-entry queue between the parser and the row writer.
`timescale 1ns / 1ps

module pcrle_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

@@ sv/pcrle_front.sv @@
// Stream parser: tracks position and run state, turns each beat into a queue entry.
`timescale 1ns / 1ps

module pcrle_front #(
   parameter int MAX_ROWS    = 512,
   parameter int MAX_COLUMNS = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [9:0]           csr_data,
   input  logic                 accept,
   input  logic                 cmd,
   input  logic [7:0]           data,
   output pcrle_pkg::entry_type entry
);

   localparam int RW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
   localparam int HW  = $clog2(MAX_ROWS + 1) > 10 ? $clog2(MAX_ROWS + 1) : 10;
   localparam int CW  = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
   localparam int NW  = $clog2(MAX_COLUMNS + 1) > 8 ? $clog2(MAX_COLUMNS + 1) : 8;

   logic [7:0]    column_count_ff;
   logic [9:0]    row_count_ff;

   logic          bank_ff, bank_in;
   logic [CW-1:0] col_ff, col_in;
   logic [1:0]    plane_ff, plane_in;
   logic [RW-1:0] row_ff, row_in;
   logic [2:0]    phase_ff, phase_in;
   logic [2:0]    run_op_ff, run_op_in;
   logic [8:0]    run_left_ff, run_left_in;
   logic [7:0]    fill_first_ff, fill_first_in;
   logic [7:0]    fill_second_ff, fill_second_in;
   logic          pair_ff, pair_in;
   logic          inv_pend_ff, inv_pend_in;
   logic          run_inv_ff, run_inv_in;

   logic [HW-1:0] height;
   logic [NW-1:0] ncols;
   logic [HW-1:0] row_next;
   logic [NW-1:0] col_next;
   logic          ended;
   logic          err;
   logic          do_write;
   logic          done;
   logic [1:0]    src;
   logic [7:0]    lit;
   logic [8:0]    left_after;
   logic [31:0]   row_wide;
   logic [31:0]   col_wide;

   // Effective limits: zero acts as one, clamp to the store size
   always_comb begin
      height = (row_count_ff == 10'd0) ? HW'(1) : HW'(row_count_ff);
      if (height > HW'(MAX_ROWS)) begin
         height = HW'(MAX_ROWS);
      end
      ncols = (column_count_ff == 8'd0) ? NW'(1) : NW'(column_count_ff);
      if (ncols > NW'(MAX_COLUMNS)) begin
         ncols = NW'(MAX_COLUMNS);
      end
   end

   always_comb begin
      bank_in        = bank_ff;
      col_in         = col_ff;
      plane_in       = plane_ff;
      row_in         = row_ff;
      phase_in       = phase_ff;
      run_op_in      = run_op_ff;
      run_left_in    = run_left_ff;
      fill_first_in  = fill_first_ff;
      fill_second_in = fill_second_ff;
      pair_in        = pair_ff;
      inv_pend_in    = inv_pend_ff;
      run_inv_in     = run_inv_ff;
      do_write       = 1'b0;
      done           = 1'b0;
      src            = pcrle_pkg::SRC_LIT;
      lit            = data;
      left_after     = run_left_ff;

      row_next = HW'(row_ff) + HW'(1);
      ended    = !(row_next < height);
      col_next = NW'(col_ff) + NW'(1);

      err = (cmd == pcrle_pkg::CMD_STEP) != (phase_ff == pcrle_pkg::PH_RUN);

      if (err) begin
         // wrong kind: dropped
      end else if (cmd == pcrle_pkg::CMD_STEP) begin
         do_write = 1'b1;
         case (run_op_ff)
            pcrle_pkg::OP_COPY_PREV[2:0]: begin
               if (col_ff == '0) begin
                  lit = 8'h00;
               end else begin
                  src = pcrle_pkg::SRC_PREV;
               end
            end
            pcrle_pkg::OP_FILL[2:0]: begin
               lit = fill_first_ff;
            end
            pcrle_pkg::OP_PAIR[2:0]: begin
               lit = pair_ff ? fill_second_ff : fill_first_ff;
            end
            default: begin
               src = pcrle_pkg::SRC_PLANE;
            end
         endcase
         if (run_op_ff == pcrle_pkg::OP_PAIR[2:0] && !pair_ff) begin
            pair_in = 1'b1;
         end else begin
            pair_in = 1'b0;
            if (run_left_ff != 9'd0) begin
               left_after = run_left_ff - 9'd1;
            end
         end
         run_left_in = left_after;
         if (ended || left_after == 9'd0) begin
            phase_in = pcrle_pkg::PH_OPCODE;
         end
      end else begin
         case (phase_ff)
            pcrle_pkg::PH_OPCODE: begin
               if (data <= pcrle_pkg::OP_COPY_P2) begin
                  run_op_in = data[2:0];
                  phase_in  = pcrle_pkg::PH_COUNT;
               end else if (data == pcrle_pkg::OP_SET_INV) begin
                  inv_pend_in = 1'b1;
               end else if (data == pcrle_pkg::OP_LITERAL) begin
                  phase_in = pcrle_pkg::PH_LITERAL;
               end else begin
                  do_write = 1'b1;
               end
            end
            pcrle_pkg::PH_COUNT: begin
               run_left_in = {1'b0, data} + 9'd1;
               pair_in     = 1'b0;
               if (run_op_ff == pcrle_pkg::OP_FILL[2:0] ||
                   run_op_ff == pcrle_pkg::OP_PAIR[2:0]) begin
                  phase_in = pcrle_pkg::PH_FIRST;
               end else begin
                  if (run_op_ff >= pcrle_pkg::OP_COPY_P0[2:0]) begin
                     run_inv_in  = inv_pend_ff;
                     inv_pend_in = 1'b0;
                  end
                  phase_in = pcrle_pkg::PH_RUN;
               end
            end
            pcrle_pkg::PH_FIRST: begin
               fill_first_in = data;
               phase_in = (run_op_ff == pcrle_pkg::OP_PAIR[2:0]) ?
                          pcrle_pkg::PH_SECOND : pcrle_pkg::PH_RUN;
            end
            pcrle_pkg::PH_SECOND: begin
               fill_second_in = data;
               phase_in       = pcrle_pkg::PH_RUN;
            end
            default: begin
               do_write = 1'b1;
               phase_in = pcrle_pkg::PH_OPCODE;
            end
         endcase
      end

      // Advance position after a row write
      if (do_write) begin
         if (!ended) begin
            row_in = row_next[RW-1:0];
         end else begin
            row_in   = '0;
            plane_in = plane_ff + 2'd1;
            if (plane_ff == 2'd3) begin
               bank_in = ~bank_ff;
               if (col_next >= ncols) begin
                  col_in = '0;
                  done   = 1'b1;
               end else begin
                  col_in = col_next[CW-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      row_wide = 32'(row_ff);
      col_wide = 32'(col_ff);
      entry.we             = do_write;
      entry.bank           = bank_ff;
      entry.addr           = pcrle_pkg::ADDR_W'(row_ff);
      entry.plane          = plane_ff;
      entry.src            = src;
      entry.lit            = lit;
      entry.src_plane      = run_op_ff[1:0] - pcrle_pkg::OP_COPY_P0[1:0];
      entry.invert         = run_inv_ff;
      entry.emit           = do_write && (plane_ff == 2'd3);
      entry.column         = (do_write && plane_ff == 2'd3) ? col_wide[6:0] : 7'd0;
      entry.row            = (do_write && plane_ff == 2'd3) ? row_wide[8:0] : 9'd0;
      entry.want_step      = (phase_in == pcrle_pkg::PH_RUN);
      entry.image_done     = done;
      entry.protocol_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 8'd80;
         row_count_ff    <= 10'd400;
      end else if (csr_we) begin
         if (csr_index == pcrle_pkg::CSR_COLUMN_COUNT) begin
            column_count_ff <= csr_data[7:0];
         end else begin
            row_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff        <= 1'b0;
         col_ff         <= '0;
         plane_ff       <= 2'd0;
         row_ff         <= '0;
         phase_ff       <= pcrle_pkg::PH_OPCODE;
         run_op_ff      <= 3'd0;
         run_left_ff    <= 9'd0;
         fill_first_ff  <= 8'd0;
         fill_second_ff <= 8'd0;
         pair_ff        <= 1'b0;
         inv_pend_ff    <= 1'b0;
         run_inv_ff     <= 1'b0;
      end else if (accept) begin
         bank_ff        <= bank_in;
         col_ff         <= col_in;
         plane_ff       <= plane_in;
         row_ff         <= row_in;
         phase_ff       <= phase_in;
         run_op_ff      <= run_op_in;
         run_left_ff    <= run_left_in;
         fill_first_ff  <= fill_first_in;
         fill_second_ff <= fill_second_in;
         pair_ff        <= pair_in;
         inv_pend_ff    <= inv_pend_in;
         run_inv_ff     <= run_inv_in;
      end
   end

endmodule

@@ sv/pcrle_back.sv @@
// Row writer: read-modify-write of the column store and the result register.
`timescale 1ns / 1ps

module pcrle_back #(
   parameter int MAX_ROWS = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  pcrle_pkg::entry_type q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_pixels_valid,
   output logic [6:0]           rsp_column,
   output logic [8:0]           rsp_row,
   output logic [31:0]          rsp_pixels,
   output logic                 rsp_want_step,
   output logic                 rsp_image_done,
   output logic                 rsp_protocol_error
);

   localparam int AW = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

   pcrle_pkg::entry_type exe_ff;
   logic                 exe_v_ff;
   logic                 exe_adv;

   logic          lw_v_ff;
   logic          lw_bank_ff;
   logic [AW-1:0] lw_addr_ff;
   logic [31:0]   lw_data_ff;

   logic [31:0] rd0, rd1;
   logic [31:0] cur_word, oth_word, raw_cur, raw_oth;
   logic [7:0]  value;
   logic [31:0] merged;
   logic [AW-1:0] exe_addr;
   logic        wr;

   logic        out_v_ff;
   logic        out_pv_ff;
   logic [6:0]  out_col_ff;
   logic [8:0]  out_row_ff;
   logic [31:0] out_pix_ff;
   logic        out_ws_ff;
   logic        out_done_ff;
   logic        out_err_ff;

   assign exe_adv = exe_v_ff && (!out_v_ff || !rsp_stall);
   assign q_pop   = q_not_empty && (!exe_v_ff || exe_adv);
   assign exe_addr = exe_ff.addr[AW-1:0];
   assign wr      = exe_adv && exe_ff.we;

   pcrle_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_bank0 (
      .clock (clock),
      .we    (wr && !exe_ff.bank),
      .waddr (exe_addr),
      .wdata (merged),
      .re    (q_pop),
      .raddr (q_entry.addr[AW-1:0]),
      .rdata (rd0)
   );

   pcrle_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_bank1 (
      .clock (clock),
      .we    (wr && exe_ff.bank),
      .waddr (exe_addr),
      .wdata (merged),
      .re    (q_pop),
      .raddr (q_entry.addr[AW-1:0]),
      .rdata (rd1)
   );

   // The previous write may land in the cycle this row was read
   always_comb begin
      raw_cur = exe_ff.bank ? rd1 : rd0;
      raw_oth = exe_ff.bank ? rd0 : rd1;
      cur_word = (lw_v_ff && lw_bank_ff == exe_ff.bank && lw_addr_ff == exe_addr) ?
                 lw_data_ff : raw_cur;
      oth_word = (lw_v_ff && lw_bank_ff != exe_ff.bank && lw_addr_ff == exe_addr) ?
                 lw_data_ff : raw_oth;
      case (exe_ff.src)
         pcrle_pkg::SRC_PREV:  value = 8'(oth_word >> {exe_ff.plane, 3'b000});
         pcrle_pkg::SRC_PLANE: value = 8'(cur_word >> {exe_ff.src_plane, 3'b000}) ^
                                       {8{exe_ff.invert}};
         default:              value = exe_ff.lit;
      endcase
      merged = (cur_word & ~(32'h0000_00FF << {exe_ff.plane, 3'b000})) |
               (32'(value) << {exe_ff.plane, 3'b000});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_v_ff <= 1'b0;
         lw_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            exe_v_ff <= 1'b1;
         end else if (exe_adv) begin
            exe_v_ff <= 1'b0;
         end
         if (wr) begin
            lw_v_ff <= 1'b1;
         end
         if (exe_adv) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         exe_ff <= q_entry;
      end
      if (wr) begin
         lw_bank_ff <= exe_ff.bank;
         lw_addr_ff <= exe_addr;
         lw_data_ff <= merged;
      end
      if (exe_adv) begin
         out_pv_ff   <= exe_ff.emit;
         out_col_ff  <= exe_ff.column;
         out_row_ff  <= exe_ff.row;
         out_pix_ff  <= exe_ff.emit ? pcrle_pkg::make_pixels(merged) : 32'd0;
         out_ws_ff   <= exe_ff.want_step;
         out_done_ff <= exe_ff.image_done;
         out_err_ff  <= exe_ff.protocol_error;
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_pixels_valid   = out_pv_ff;
   assign rsp_column         = out_col_ff;
   assign rsp_row            = out_row_ff;
   assign rsp_pixels         = out_pix_ff;
   assign rsp_want_step      = out_ws_ff;
   assign rsp_image_done     = out_done_ff;
   assign rsp_protocol_error = out_err_ff;

endmodule

@@ sv/planar_column_rle_image_decoder.sv @@
// Top level of the planar column RLE image decoder.
`timescale 1ns / 1ps

// Channel   Dir   Beat payload
// req_      in    cmd, data                      (valid / stall)
// rsp_      out   pixels_valid, column, row, pixels,
//                 want_step, image_done, protocol_error (valid / stall)
// csr_      in    we, index, data                (write only)
//
// One beat per cycle while rsp is not stalled; an accepted req beat goes into the queue,
// is popped with the store read, then merged into the result register that drives rsp_valid.
// The store read port feeding the read-modify-write sets the rate; the last written
// word is forwarded so consecutive rows need no bubble.
// Reset is synchronous and clears control state only; the store needs no clearing.
// A stalled rsp fills the two-entry queue, then req_stall rises.

module planar_column_rle_image_decoder #(
   parameter int MAX_ROWS    = 512,
   parameter int MAX_COLUMNS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pixels_valid,
   output logic [6:0]  rsp_column,
   output logic [8:0]  rsp_row,
   output logic [31:0] rsp_pixels,
   output logic        rsp_want_step,
   output logic        rsp_image_done,
   output logic        rsp_protocol_error
);

   pcrle_pkg::entry_type front_entry;
   pcrle_pkg::entry_type q_entry;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 q_pop;
   logic                 req_accept;

   // Front takes a beat whenever the queue has room
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   pcrle_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (req_accept),
      .cmd       (req_cmd),
      .data      (req_data),
      .entry     (front_entry)
   );

   pcrle_fifo #(.WIDTH($bits(pcrle_pkg::entry_type))) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_entry)
   );

   pcrle_back #(.MAX_ROWS(MAX_ROWS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_entry            (q_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixels_valid   (rsp_pixels_valid),
      .rsp_column         (rsp_column),
      .rsp_row            (rsp_row),
      .rsp_pixels         (rsp_pixels),
      .rsp_want_step      (rsp_want_step),
      .rsp_image_done     (rsp_image_done),
      .rsp_protocol_error (rsp_protocol_error)
   );

   // Image end only comes with a plane-3 row write
   a_done_has_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_pixels_valid)
      else $error("image_done without pixels");

   // An ignored beat writes nothing
   a_err_no_pixels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_protocol_error |-> !rsp_pixels_valid && !rsp_image_done)
      else $error("ignored beat produced a row");

   // No pixel group: position and pixels read as zero
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixels_valid |-> rsp_pixels == 32'd0 && rsp_row == 9'd0 &&
                                         rsp_column == 7'd0)
      else $error("fields not cleared without pixels");

   // Queue full can only follow an accepted beat
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(q_full) |-> $past(req_accept))
      else $error("queue filled without a push");

endmodule
